### design/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg: shared definitions for the sliding window mode filter
// Window and label sizes, derived widths and the types that carry the
// per-cell label match vectors.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

  // Window length and number of countable labels.
  localparam int WINDOW_LEN  = 10;
  localparam int LABEL_COUNT = 8;

  // Field widths.
  localparam int LABEL_W = 3;
  localparam int CFG_W   = 4;

  // A count must hold every value from zero up to the window length.
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  // Reset value of the labels-in-use register.
  localparam logic [CFG_W-1:0] LABELS_IN_USE_RESET = CFG_W'(8);

  // One bit per label: set where a cell holds that label and it is counted.
  typedef logic [LABEL_COUNT-1:0] hit_vec_t;
  typedef hit_vec_t [WINDOW_LEN-1:0] hit_arr_t;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [CNT_W-1:0] count_t;

endpackage

`default_nettype wire

### design/swmf_if.sv
// ----------------------------------------------------------------------------
// swmf_if: stream channels of the sliding window mode filter
// Valid/ready channels for incoming labels and for filtered labels.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmf_label_if;
  import swmf_pkg::*;

  logic   valid;
  logic   ready;
  label_t new_label;

  modport source (output valid, output new_label, input ready);
  modport sink (input valid, input new_label, output ready);
endinterface

interface swmf_mode_if;
  import swmf_pkg::*;

  logic   valid;
  logic   ready;
  label_t mode_label;

  modport source (output valid, output mode_label, input ready);
  modport sink (input valid, input mode_label, output ready);
endinterface

`default_nettype wire

### design/sliding_window_mode_filter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_mode_filter_top: majority filter over recent class labels
// Keeps the last ten labels and reports the most frequent counted one.
// ----------------------------------------------------------------------------
// Usage:
//   label_stream carries one class label per word; mode_stream returns one
//   filtered label per accepted word, in order. cfg_we/cfg_wdata write the
//   number of labels counted (labels 0 up to that number minus one; values
//   above the label count saturate); the user must write them only while
//   the block is idle, which the block itself does not enforce.
//   Each word shifts into a row of window cells; the oldest label drops out.
//   The count stage then registers the per-label sums of the cell match
//   vectors, and the output register takes the winner picked from them.
//   One word per cycle is sustained; the count stage and the output
//   register act as buffers, so input is still taken while a result waits.
//   Once both hold a word and the window holds one more word that is not yet
//   counted, label_stream.ready drops until mode_stream drains.
//   Reset clears the window to empty, empties the pipeline and sets the
//   label count to eight; an empty window yields label 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_mode_filter_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  swmf_label_if.sink                        label_stream,
  swmf_mode_if.source                       mode_stream,
  input  wire logic                         cfg_we,
  input  wire logic [swmf_pkg::CFG_W-1:0]   cfg_wdata
);
  import swmf_pkg::*;

  logic [CFG_W-1:0] labels_in_use;
  logic [CFG_W-1:0] active;
  hit_vec_t         label_en;
  logic             accept;
  logic             pend;
  logic             free;
  label_t           chain_label [WINDOW_LEN+1];
  logic             chain_valid [WINDOW_LEN+1];
  hit_arr_t         hits;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      labels_in_use <= LABELS_IN_USE_RESET;
    end else if (cfg_we) begin
      labels_in_use <= cfg_wdata;
    end
  end

  // Saturate the label count and build the counted-label mask.
  always_comb begin
    if (int'(labels_in_use) > LABEL_COUNT) begin
      active = CFG_W'(LABEL_COUNT);
    end else begin
      active = labels_in_use;
    end
    for (int l = 0; l < LABEL_COUNT; l++) begin
      label_en[l] = int'(active) > l;
    end
  end

  // A new word may enter once the previous window state has been counted.
  assign label_stream.ready = !pend || free;
  assign accept             = label_stream.valid && label_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (free) begin
      pend <= 1'b0;
    end
  end

  // Window cells, newest at the head of the row.
  assign chain_label[0] = label_stream.new_label;
  assign chain_valid[0] = 1'b1;

  for (genvar c = 0; c < WINDOW_LEN; c++) begin : g_cell
    swmf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept),
      .label_in  (chain_label[c]),
      .valid_in  (chain_valid[c]),
      .label_en  (label_en),
      .label_out (chain_label[c+1]),
      .valid_out (chain_valid[c+1]),
      .hit       (hits[c])
    );
  end

  // Count and pick stages with the output register.
  swmf_vote u_vote (
    .clk         (clk),
    .rst         (rst),
    .pend        (pend),
    .hits        (hits),
    .free        (free),
    .mode_stream (mode_stream)
  );

endmodule

`default_nettype wire

### design/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell: one window slot
// Holds a label and its valid flag, passes them to the next slot on every
// shift and decodes the held label into a vector of counted-label hits.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      shift,
  input  wire swmf_pkg::label_t          label_in,
  input  wire logic                      valid_in,
  input  wire swmf_pkg::hit_vec_t        label_en,
  output swmf_pkg::label_t               label_out,
  output logic                           valid_out,
  output swmf_pkg::hit_vec_t             hit
);
  import swmf_pkg::*;

  label_t label;
  logic   valid;

  // The valid flag is control state; the label is masked by it.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      label <= label_in;
    end
  end

  assign label_out = label;
  assign valid_out = valid;

  // Decode the held label; labels beyond the field range never match.
  always_comb begin
    hit = '0;
    for (int l = 0; l < LABEL_COUNT; l++) begin
      if (l < (1 << LABEL_W)) begin
        hit[l] = valid && label_en[l] && (label == LABEL_W'(l));
      end
    end
  end

endmodule

`default_nettype wire

### design/swmf_vote.sv
// ----------------------------------------------------------------------------
// swmf_vote: count and pick stages
// Sums the hit vectors of all window cells into one count per label, then
// selects the label with the highest count, lowest label on a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_vote (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pend,
  input  wire swmf_pkg::hit_arr_t   hits,
  output logic                      free,
  swmf_mode_if.source               mode_stream
);
  import swmf_pkg::*;

  count_t counts [LABEL_COUNT];
  count_t counts_next [LABEL_COUNT];
  logic   cnt_valid;
  logic   out_adv;
  label_t best_label;
  count_t best_count;
  label_t mode;
  logic   out_valid;

  // Each stage moves on when the stage after it is empty or moving.
  assign out_adv = !out_valid || mode_stream.ready;
  assign free    = !cnt_valid || out_adv;

  // Per-label population count over the window cells.
  always_comb begin
    for (int l = 0; l < LABEL_COUNT; l++) begin
      counts_next[l] = '0;
      for (int c = 0; c < WINDOW_LEN; c++) begin
        counts_next[l] = counts_next[l] + CNT_W'(hits[c][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= 1'b0;
    end else if (free) begin
      cnt_valid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (free && pend) begin
      counts <= counts_next;
    end
  end

  // Strictly greater wins, so the lowest label keeps a tie.
  always_comb begin
    best_label = '0;
    best_count = '0;
    for (int l = 0; l < LABEL_COUNT; l++) begin
      if (counts[l] > best_count) begin
        best_count = counts[l];
        best_label = LABEL_W'(l);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= cnt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && cnt_valid) begin
      mode <= best_label;
    end
  end

  assign mode_stream.valid      = out_valid;
  assign mode_stream.mode_label = mode;

endmodule

`default_nettype wire
